/* hdl/lir_pkg.sv */
package lir_pkg;

    // Width of the phase step register as seen on the configuration port.
    localparam int STEP_W = 41;

    // Largest number of output samples that one input sample may produce.
    localparam int MAX_RUN   = 64;
    localparam int RUN_CNT_W = $clog2(MAX_RUN);

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic prime;   // first sample after reset or step write: store it
        logic skip;    // phase already past one: drop it by one, no output
        logic start;   // latch the current sample and its difference
        logic mul;     // form the product of difference and phase fraction
        logic emit;    // load the output register and advance the phase
    } lir_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic primed;        // a previous sample is held
        logic phase_lt_one;  // phase is below one
        logic out_free;      // output register can take a new sample
        logic last_next;     // the sample about to be emitted ends the run
    } lir_status_t;

endpackage

/* hdl/lir_ctrl.sv */
module lir_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  lir_pkg::lir_status_t status,
    output lir_pkg::lir_cmd_t    cmd
);
    import lir_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    // Input transactions are taken only between runs.
    assign s_ready = (state_reg == ST_IDLE);

    // Next state and command decode.
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (!status.primed) begin
                        cmd.prime = 1'b1;
                    end else if (status.phase_lt_one) begin
                        cmd.start  = 1'b1;
                        state_next = ST_MUL;
                    end else begin
                        cmd.skip = 1'b1;
                    end
                end
            end
            ST_MUL: begin
                cmd.mul    = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (status.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = status.last_next ? ST_IDLE : ST_MUL;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

/* hdl/lir_datapath.sv */
module lir_datapath #(
    parameter int PHASE_FRAC_BITS = 32,
    parameter int SAMPLE_BITS     = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [lir_pkg::STEP_W-1:0]     cfg_phase_step,
    input  logic signed [SAMPLE_BITS-1:0]  s_sample_in,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic signed [SAMPLE_BITS-1:0]  m_sample_out,
    output logic                           m_last_of_run,
    input  lir_pkg::lir_cmd_t              cmd,
    output lir_pkg::lir_status_t           status
);
    import lir_pkg::*;

    localparam int PW     = PHASE_FRAC_BITS + 9;
    localparam int PROD_W = SAMPLE_BITS + PHASE_FRAC_BITS + 2;
    localparam int SUM_W  = SAMPLE_BITS + 2;

    localparam logic [PW-1:0] PHASE_ONE = {{(PW-1){1'b0}}, 1'b1} << PHASE_FRAC_BITS;
    localparam logic [PW-1:0] STEP_MIN  = PHASE_ONE >> 6;
    localparam logic [PW-1:0] STEP_MAX  = PHASE_ONE << 8;
    localparam logic [STEP_W-1:0] STEP_MIN_W = STEP_W'(STEP_MIN);
    localparam logic [STEP_W-1:0] STEP_MAX_W = STEP_W'(STEP_MAX);
    localparam logic [RUN_CNT_W-1:0] CNT_LAST = RUN_CNT_W'(MAX_RUN - 1);

    logic [PW-1:0]                   step_reg;
    logic [PW-1:0]                   phase_reg;
    logic signed [SAMPLE_BITS-1:0]   prev_reg;
    logic                            primed_reg;
    logic signed [SAMPLE_BITS-1:0]   cur_reg;
    logic signed [SAMPLE_BITS:0]     diff_reg;
    logic signed [PROD_W-1:0]        prod_reg;
    logic [RUN_CNT_W-1:0]            cnt_reg;
    logic                            out_valid_reg;
    logic signed [SAMPLE_BITS-1:0]   out_sample_reg;
    logic                            out_last_reg;

    logic [PW-1:0]                   step_clamped;
    logic [PW-1:0]                   phase_sum;
    logic                            last_next;
    logic signed [SAMPLE_BITS:0]     diff_next;
    logic signed [PHASE_FRAC_BITS:0] frac;
    logic signed [SUM_W-1:0]         scaled;
    logic signed [SUM_W-1:0]         interp;
    logic signed [SAMPLE_BITS-1:0]   interp_sat;

    // The step is clamped when written, so one input gives at most MAX_RUN outputs.
    always_comb begin
        if (cfg_phase_step < STEP_MIN_W) begin
            step_clamped = STEP_MIN;
        end else if (cfg_phase_step > STEP_MAX_W) begin
            step_clamped = STEP_MAX;
        end else begin
            step_clamped = PW'(cfg_phase_step);
        end
    end

    // Phase advance and end-of-run detection.
    assign phase_sum = phase_reg + step_reg;
    assign last_next = (phase_sum >= PHASE_ONE) || (cnt_reg == CNT_LAST);

    // Difference of the new sample and the held one.
    assign diff_next = (SAMPLE_BITS + 1)'(s_sample_in) - (SAMPLE_BITS + 1)'(prev_reg);

    // Fractional part of the phase; the run only proceeds while phase is below one.
    assign frac = $signed({1'b0, phase_reg[PHASE_FRAC_BITS-1:0]});

    // Arithmetic shift of the product rounds towards minus infinity.
    assign scaled = SUM_W'(prod_reg >>> PHASE_FRAC_BITS);
    assign interp = SUM_W'(prev_reg) + scaled;

    // Saturate when the top bits disagree with the sample's sign bit.
    always_comb begin
        if (interp[SUM_W-1:SAMPLE_BITS-1] == {(SUM_W - SAMPLE_BITS + 1){1'b0}} ||
            interp[SUM_W-1:SAMPLE_BITS-1] == {(SUM_W - SAMPLE_BITS + 1){1'b1}}) begin
            interp_sat = interp[SAMPLE_BITS-1:0];
        end else if (interp[SUM_W-1]) begin
            interp_sat = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
        end else begin
            interp_sat = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
        end
    end

    // Run state: step, phase, previous sample and primed flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg   <= PHASE_ONE;
            phase_reg  <= '0;
            prev_reg   <= '0;
            primed_reg <= 1'b0;
        end else if (cfg_we) begin
            step_reg   <= step_clamped;
            phase_reg  <= '0;
            prev_reg   <= '0;
            primed_reg <= 1'b0;
        end else if (cmd.prime) begin
            phase_reg  <= '0;
            prev_reg   <= s_sample_in;
            primed_reg <= 1'b1;
        end else if (cmd.skip) begin
            phase_reg <= phase_reg - PHASE_ONE;
            prev_reg  <= s_sample_in;
        end else if (cmd.emit) begin
            if (last_next) begin
                phase_reg <= phase_sum - PHASE_ONE;
                prev_reg  <= cur_reg;
            end else begin
                phase_reg <= phase_sum;
            end
        end
    end

    // Working registers of the interpolation.
    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            cur_reg  <= s_sample_in;
            diff_reg <= diff_next;
        end
        if (cmd.mul) begin
            prod_reg <= PROD_W'(diff_reg) * PROD_W'(frac);
        end
    end

    // Output count within the current run.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (cmd.start) begin
            cnt_reg <= '0;
        end else if (cmd.emit) begin
            cnt_reg <= cnt_reg + RUN_CNT_W'(1);
        end
    end

    // Output register: holds a result until its transaction completes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            out_sample_reg <= interp_sat;
            out_last_reg   <= last_next;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_sample_out  = out_sample_reg;
    assign m_last_of_run = out_last_reg;

    assign status.primed       = primed_reg;
    assign status.phase_lt_one = (phase_reg < PHASE_ONE);
    assign status.out_free     = !out_valid_reg || m_ready;
    assign status.last_next    = last_next;

endmodule

/* hdl/linear_interp_resampler.sv */
// Linear interpolation sample-rate converter.
//
// Input samples arrive on the s_ channel, interpolated samples leave on the
// m_ channel with m_last_of_run marking the final output caused by an input.
// The phase step (Q PHASE_FRAC_BITS, input samples per output sample) is set
// through the cfg_ channel; a write also clears the phase and the held sample.
// The step is clamped to the range one sixty-fourth to 256.
//
// The first sample after reset or a step write only primes the block. Each
// later sample is accepted in the idle state; each output then goes through
// the multiply state for the product and the emit state for the add and
// saturation into the output register. An input gives 0 to 64 outputs, and
// its first output is loaded in the emit state that follows its acceptance.
// A new input is taken as soon as the last output of a run has been loaded.
//
// Reset restores a step of one, clears the phase and the primed flag and
// empties the output register. When the receiver stalls, the result waits in
// the output register and the run pauses until the transaction completes.
module linear_interp_resampler #(
    parameter int PHASE_FRAC_BITS = 32,
    parameter int SAMPLE_BITS     = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [lir_pkg::STEP_W-1:0]     cfg_phase_step,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic signed [SAMPLE_BITS-1:0]  s_sample_in,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic signed [SAMPLE_BITS-1:0]  m_sample_out,
    output logic                           m_last_of_run
);
    import lir_pkg::*;

    lir_cmd_t    cmd;
    lir_status_t status;
    logic        cfg_we;

    // A step write is taken at once; it is meant to arrive only while the block is idle.
    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    lir_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    lir_datapath #(
        .PHASE_FRAC_BITS (PHASE_FRAC_BITS),
        .SAMPLE_BITS     (SAMPLE_BITS)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_phase_step (cfg_phase_step),
        .s_sample_in    (s_sample_in),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_sample_out   (m_sample_out),
        .m_last_of_run  (m_last_of_run),
        .cmd            (cmd),
        .status         (status)
    );

endmodule

/* hdl/lir_checker.sv */
module lir_props #(
    parameter int SAMPLE_BITS = 16
) (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_valid,
    input logic                          s_ready,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic signed [SAMPLE_BITS-1:0] m_sample_out,
    input logic                          m_last_of_run
);

    // After reset the block is ready for input and has no result pending.
    a_reset_state: assert property (@(posedge aclk)
        !aresetn |=> s_ready && !m_valid)
        else $error("block not idle after reset");

    // A stalled result keeps its value until the transaction completes.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_sample_out) && $stable(m_last_of_run))
        else $error("pending result changed before its transaction");

    // Input is taken only between runs, so any result still waiting ends a run.
    a_ready_only_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready && m_valid |-> m_last_of_run)
        else $error("input ready while a run is still in progress");

endmodule

bind linear_interp_resampler lir_props #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_lir_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_sample_out  (m_sample_out),
    .m_last_of_run (m_last_of_run)
);

/* tb/lir_checker.sv */
// Watches the configuration, sample and result channels of the resampler.
// It keeps its own copy of the step, phase and held sample, works out the
// interpolated outputs for every accepted sample transaction and compares
// each result transaction against the oldest outstanding expectation.
module lir_checker
    import lir_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [STEP_W-1:0]  cfg_phase_step,
    input  logic               s_valid,
    input  logic               s_ready,
    input  logic signed [15:0] s_sample_in,
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic signed [15:0] m_sample_out,
    input  logic               m_last_of_run,
    output int                 outstanding,
    output int                 fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SAMPLE_W     = 16;
    localparam int FRAC_BITS    = 32;
    localparam int REPORT_LIMIT = 10;

    localparam logic [STEP_W-1:0] PHASE_ONE = 41'd1 << FRAC_BITS;
    localparam logic [STEP_W-1:0] STEP_MIN  = PHASE_ONE >> 6;
    localparam logic [STEP_W-1:0] STEP_MAX  = PHASE_ONE << 8;

    localparam longint SAMPLE_MAX = 32767;
    localparam longint SAMPLE_MIN = -32768;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       last;
    } interp_point_t;

    // Interpolated outputs still owed by the block, oldest first.
    interp_point_t interp_q[$];

    logic [STEP_W-1:0]          step_reg;
    logic [STEP_W-1:0]          phase;
    logic signed [SAMPLE_W-1:0] held;
    logic                       primed;
    int                         errors = 0;

    // Count a failure and describe the first few of them.
    task automatic flag(input string msg);
        if (errors < REPORT_LIMIT)
            $display("%0t lir_checker: %s", $time, msg);
        errors++;
    endtask

    // Work out the outputs caused by one input sample and queue them.
    task automatic interpolate(input logic signed [SAMPLE_W-1:0] cur);
        logic [STEP_W-1:0] eff_step;
        logic [STEP_W-1:0] next_phase;
        longint            diff;
        longint            value;
        int                n;
        interp_point_t     pt;

        eff_step = step_reg;
        if (eff_step < STEP_MIN)
            eff_step = STEP_MIN;
        if (eff_step > STEP_MAX)
            eff_step = STEP_MAX;

        // The first sample of a stream is only held.
        if (!primed) begin
            held   = cur;
            phase  = '0;
            primed = 1'b1;
            return;
        end

        n = 0;
        while (phase < PHASE_ONE && n < MAX_RUN) begin
            diff  = longint'(cur) - longint'(held);
            // Arithmetic shift of the signed product rounds towards minus infinity.
            value = longint'(held) + ((diff * longint'(phase)) >>> FRAC_BITS);
            if (value > SAMPLE_MAX)
                value = SAMPLE_MAX;
            if (value < SAMPLE_MIN)
                value = SAMPLE_MIN;
            next_phase = phase + eff_step;
            pt.sample  = value[SAMPLE_W-1:0];
            pt.last    = (next_phase >= PHASE_ONE) || (n == MAX_RUN - 1);
            interp_q.push_back(pt);
            phase = next_phase;
            n++;
        end

        phase = phase - PHASE_ONE;
        held  = cur;
    endtask

    // All channel activity is sampled at the rising edge, in one process.
    always @(posedge aclk) begin : watch
        interp_point_t want;

        if (!aresetn) begin
            step_reg = PHASE_ONE;
            phase    = '0;
            held     = '0;
            primed   = 1'b0;
            interp_q.delete();
        end else begin
            // A step write restarts the stream.
            if (cfg_valid && cfg_ready) begin
                step_reg = cfg_phase_step;
                phase    = '0;
                held     = '0;
                primed   = 1'b0;
            end

            if (s_valid && s_ready)
                interpolate(s_sample_in);

            if (m_valid && m_ready) begin
                if (interp_q.size() == 0) begin
                    flag($sformatf("unexpected result transaction: sample %0d, last %0b",
                                   m_sample_out, m_last_of_run));
                end else begin
                    want = interp_q.pop_front();
                    if (m_sample_out !== want.sample)
                        flag($sformatf("sample_out expected %0d, got %0d",
                                       want.sample, m_sample_out));
                    if (m_last_of_run !== want.last)
                        flag($sformatf("last_of_run expected %0b, got %0b",
                                       want.last, m_last_of_run));
                end
            end
        end

        outstanding <= interp_q.size();
        fail_count  <= errors;
    end

endmodule

/* tb/tb_linear_interp_resampler.sv */
// Stimulus for the resampler: a directed pass over the sample and step
// extremes, then random streams under a range of step settings, with random
// gaps on both channels and two long stalls of the result channel.
module tb_linear_interp_resampler;
    timeunit 1ns;
    timeprecision 1ps;

    import lir_pkg::*;

    localparam logic signed [15:0] SAMPLE_MAX = 16'sh7FFF;
    localparam logic signed [15:0] SAMPLE_MIN = 16'sh8000;

    localparam logic [STEP_W-1:0] STEP_ONE   = 41'd1 << 32;
    localparam logic [STEP_W-1:0] STEP_LOW   = STEP_ONE >> 6;
    localparam logic [STEP_W-1:0] STEP_HIGH  = STEP_ONE << 8;
    localparam logic [STEP_W-1:0] STEP_ZERO  = '0;
    localparam logic [STEP_W-1:0] STEP_ALL1  = '1;
    localparam logic [STEP_W-1:0] STEP_1P5   = STEP_ONE + (STEP_ONE >> 1);

    localparam int RANDOM_ITEMS = 240;
    localparam int LONG_HOLD    = 400;

    logic                aclk           = 1'b0;
    logic                aresetn        = 1'b0;
    logic                cfg_valid      = 1'b0;
    logic                cfg_ready;
    logic [STEP_W-1:0]   cfg_phase_step = '0;
    logic                s_valid        = 1'b0;
    logic                s_ready;
    logic signed [15:0]  s_sample_in    = '0;
    logic                m_valid;
    logic                m_ready        = 1'b0;
    logic signed [15:0]  m_sample_out;
    logic                m_last_of_run;

    int outstanding;
    int fail_count;
    int send_quiet = 0;

    always #6 aclk = ~aclk;

    linear_interp_resampler dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_phase_step (cfg_phase_step),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_sample_in    (s_sample_in),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_sample_out   (m_sample_out),
        .m_last_of_run  (m_last_of_run)
    );

    lir_checker checker_i (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_phase_step (cfg_phase_step),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_sample_in    (s_sample_in),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_sample_out   (m_sample_out),
        .m_last_of_run  (m_last_of_run),
        .outstanding    (outstanding),
        .fail_count     (fail_count)
    );

    // Idle cycles before the next transaction; now and then a quiet stretch
    // with no idling at all.
    function automatic int pick_wait(ref int quiet_left);
        if (quiet_left > 0) begin
            quiet_left--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) begin
            quiet_left = $urandom_range(10, 30);
            return 0;
        end
        return $urandom_range(0, 7);
    endfunction

    // Offer one sample and hold it until the transaction completes.
    task automatic push_sample(input logic signed [15:0] value);
        int gap;
        gap = pick_wait(send_quiet);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_sample_in <= value;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Stop offering samples and wait until every expected result is out.
    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (6) @(posedge aclk);
    endtask

    // Change the step once the block has gone idle.
    task automatic write_step(input logic [STEP_W-1:0] value);
        settle();
        cfg_valid      <= 1'b1;
        cfg_phase_step <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // Mostly full-range samples, some extremes and some close neighbours.
    function automatic logic signed [15:0] rand_sample(input logic signed [15:0] prev);
        case ($urandom_range(0, 9))
            0:       return $urandom_range(0, 1) ? SAMPLE_MAX : SAMPLE_MIN;
            1, 2:    return prev + 16'($signed($urandom_range(0, 127)) - 64);
            default: return 16'($urandom);
        endcase
    endfunction

    // Steps: mild up- and downsampling mostly, with raw and extreme values.
    function automatic logic [STEP_W-1:0] rand_step();
        case ($urandom_range(0, 7))
            0: return {9'($urandom_range(0, 511)), 32'($urandom)};
            1: begin
                case ($urandom_range(0, 4))
                    0:       return STEP_ZERO;
                    1:       return STEP_ALL1;
                    2:       return STEP_LOW;
                    3:       return STEP_HIGH;
                    default: return STEP_ONE;
                endcase
            end
            2, 3, 4: return {9'd0, 32'($urandom_range(32'h2000_0000, 32'hFFFF_FFFF))};
            5, 6:    return {9'($urandom_range(1, 3)), 32'($urandom)};
            default: return {9'd0, 32'($urandom)};
        endcase
    endfunction

    // Result side: random stalls, plus a long hold-off in the middle of a full
    // run while the next sample is already on offer, and another later on.
    initial begin : result_sink
        int stall;
        int taken;
        int quiet;
        taken = 0;
        quiet = 0;
        while (!aresetn) @(posedge aclk);
        forever begin
            stall = pick_wait(quiet);
            if (taken == 40 || taken == 700)
                stall = LONG_HOLD;
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            taken++;
        end
    end

    // Main stimulus and verdict.
    initial begin : stimulus
        logic signed [15:0] prev;
        int                 sent;
        int                 burst;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset step of one: each sample gives back the held one.
        push_sample(16'sd0);
        push_sample(SAMPLE_MAX);
        push_sample(SAMPLE_MIN);
        push_sample(SAMPLE_MAX);
        push_sample(-16'sd1);
        push_sample(16'sd0);
        push_sample(16'sd1);

        // Zero step is clamped to the finest ratio: full runs of outputs
        // across the widest swings.
        write_step(STEP_ZERO);
        push_sample(SAMPLE_MIN);
        push_sample(SAMPLE_MAX);
        push_sample(SAMPLE_MIN);

        // All-ones step is clamped to the coarsest ratio: mostly no outputs.
        write_step(STEP_ALL1);
        push_sample(SAMPLE_MAX);
        push_sample(SAMPLE_MIN);
        push_sample(16'sd5);
        push_sample(16'sd6);

        // Fractional downsampling with negative differences in the products.
        write_step(STEP_1P5);
        push_sample(SAMPLE_MIN);
        push_sample(SAMPLE_MAX);
        push_sample(SAMPLE_MIN);
        push_sample(SAMPLE_MAX);
        push_sample(16'sd0);
        push_sample(-16'sd1);

        // Random streams, each under a freshly written step.
        sent = 0;
        prev = '0;
        while (sent < RANDOM_ITEMS) begin
            write_step(rand_step());
            burst = $urandom_range(20, 50);
            if (burst > RANDOM_ITEMS - sent)
                burst = RANDOM_ITEMS - sent;
            repeat (burst) begin
                prev = rand_sample(prev);
                push_sample(prev);
                sent++;
            end
        end

        settle();
        repeat (20) @(posedge aclk);
        if (fail_count == 0)
            $display("[linear_interp_resampler] OK");
        else
            $display("[linear_interp_resampler] ERROR");
        $finish;
    end

    // Guard against a hung handshake.
    initial begin : watchdog
        #10_000_000;
        $display("[linear_interp_resampler] ERROR");
        $finish;
    end

endmodule
